/* rtl/exception_index_table_search_macros.svh */
// Assertion helpers shared by the search block.
`ifndef EXCEPTION_INDEX_TABLE_SEARCH_MACROS_SVH
`define EXCEPTION_INDEX_TABLE_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EITS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define EITS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/eits_pkg.sv */
`default_nettype none

package eits_pkg;

    // request kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_BASE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [9:0]  entry_index;
        logic [31:0] entry_word;
        logic [31:0] code_address;
    } in_req_t;

    typedef struct packed {
        logic        found;
        logic [9:0]  match_index;
        logic [31:0] match_address;
    } out_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_RD0,
        S_RD1,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic wr;
        logic init;
        logic probe;
        logic fetch_next;
        logic move_left;
        logic move_right;
        logic record_hit;
        logic record_miss;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic below;
        logic at_left;
        logic in_range;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/eits_ctrl.sv */
`default_nettype none

`include "exception_index_table_search_macros.svh"

module eits_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_kind,
    output logic                 in_stall,
    input  wire eits_pkg::status_t status,
    output eits_pkg::cmd_t       cmd
);

    eits_pkg::state_t state_reg;
    eits_pkg::state_t state_next;
    logic             accept;

    assign in_stall = (state_reg != eits_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eits_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            eits_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == eits_pkg::KIND_LOAD)
                    begin
                        cmd.wr = 1'b1;
                    end
                    else
                    begin
                        cmd.init   = 1'b1;
                        state_next = eits_pkg::S_PROBE;
                    end
                end
            end
            eits_pkg::S_PROBE:
            begin
                if (status.empty)
                begin
                    cmd.record_miss = 1'b1;
                    state_next      = eits_pkg::S_DONE;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = eits_pkg::S_RD0;
                end
            end
            eits_pkg::S_RD0:
            begin
                cmd.fetch_next = 1'b1;
                state_next     = eits_pkg::S_RD1;
            end
            eits_pkg::S_RD1:
            begin
                if (status.below)
                begin
                    if (status.at_left)
                    begin
                        cmd.record_miss = 1'b1;
                        state_next      = eits_pkg::S_DONE;
                    end
                    else
                    begin
                        cmd.move_right = 1'b1;
                        state_next     = eits_pkg::S_PROBE;
                    end
                end
                else if (status.in_range)
                begin
                    cmd.record_hit = 1'b1;
                    state_next     = eits_pkg::S_DONE;
                end
                else
                begin
                    cmd.move_left = 1'b1;
                    state_next    = eits_pkg::S_PROBE;
                end
            end
            eits_pkg::S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = eits_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = eits_pkg::S_IDLE;
            end
        endcase
    end

    `EITS_ASSERT_NXT(a_lookup_starts_search, clk, rst_n,
        accept && (in_kind == eits_pkg::KIND_LOOKUP), state_reg == eits_pkg::S_PROBE,
        "lookup request did not start a search")

    `EITS_ASSERT_NXT(a_done_releases, clk, rst_n,
        (state_reg == eits_pkg::S_DONE) && status.out_free, state_reg == eits_pkg::S_IDLE,
        "finished lookup did not return to idle")

endmodule

`default_nettype wire

/* rtl/eits_datapath.sv */
`default_nettype none

`include "exception_index_table_search_macros.svh"

module eits_datapath #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [eits_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [31:0]                         cfg_wdata,
    input  wire eits_pkg::in_req_t                   in_req,
    input  wire eits_pkg::cmd_t                      cmd,
    output eits_pkg::status_t                        status,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output eits_pkg::out_res_t                       out_res
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [31:0]    table_base_reg;
    logic [10:0]    entry_count_reg;

    // offset memory, one write and one registered read port
    logic [30:0]    mem [TABLE_DEPTH];
    logic [30:0]    rdata_reg;
    logic [IW-1:0]  raddr;
    logic [IW-1:0]  waddr;
    logic           wr_ok;

    // search window and probe state
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  left_reg;
    logic [CW-1:0]  right_reg;
    logic [IW-1:0]  mid_reg;
    logic [31:0]    ra_reg;
    logic [31:0]    start_reg;
    logic [31:0]    mid_addr_reg;

    // result
    logic           found_reg;
    logic [9:0]     hit_index_reg;
    logic [31:0]    hit_addr_reg;
    logic           out_valid_reg;
    eits_pkg::out_res_t out_res_reg;

    logic [CW-1:0]  n_comb;
    logic [CW:0]    mid_sum;
    logic [CW-1:0]  mid_wide;
    logic [IW-1:0]  mid_idx;
    logic [31:0]    rdata_sext;
    logic [31:0]    next_start;
    logic           last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg  <= '0;
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eits_pkg::CFG_TABLE_BASE:  table_base_reg  <= cfg_wdata;
                eits_pkg::CFG_ENTRY_COUNT: entry_count_reg <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    assign n_comb = (32'(entry_count_reg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : CW'(entry_count_reg);

    assign wr_ok = cmd.wr && (32'(in_req.entry_index) < 32'(TABLE_DEPTH));
    assign waddr = IW'(in_req.entry_index);

    assign mid_sum  = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid_wide = mid_sum[CW:1];
    assign mid_idx  = IW'(mid_wide);
    assign raddr    = cmd.probe ? mid_idx : (mid_reg + IW'(1));

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[waddr] <= in_req.entry_word[30:0];
        end
        rdata_reg <= mem[raddr];
    end

    // offset sign-extended from bit 30
    assign rdata_sext = {rdata_reg[30], rdata_reg};
    assign next_start = rdata_sext + mid_addr_reg + 32'd8;
    assign last       = (CW'(mid_reg) == (n_reg - CW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        else if (cmd.init)
        begin
            // empty table: start with an empty window
            left_reg  <= (n_comb == '0) ? CW'(1) : '0;
            right_reg <= (n_comb == '0) ? '0 : (n_comb - CW'(1));
        end
        else if (cmd.move_left)
        begin
            left_reg <= CW'(mid_reg) + CW'(1);
        end
        else if (cmd.move_right)
        begin
            right_reg <= CW'(mid_reg) - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            n_reg  <= n_comb;
            ra_reg <= in_req.code_address;
        end
        if (cmd.probe)
        begin
            mid_reg <= mid_idx;
        end
        if (cmd.fetch_next)
        begin
            start_reg    <= rdata_sext + table_base_reg + 32'({mid_reg, 3'b000});
            mid_addr_reg <= table_base_reg + 32'({mid_reg, 3'b000});
        end
        if (cmd.record_hit)
        begin
            found_reg     <= 1'b1;
            hit_index_reg <= 10'(mid_reg);
            hit_addr_reg  <= mid_addr_reg;
        end
        else if (cmd.record_miss)
        begin
            found_reg     <= 1'b0;
            hit_index_reg <= '0;
            hit_addr_reg  <= '0;
        end
        if (cmd.out_load)
        begin
            out_res_reg.found         <= found_reg;
            out_res_reg.match_index   <= hit_index_reg;
            out_res_reg.match_address <= hit_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // a next start of zero means the range runs to the top of memory
    assign status.empty    = (left_reg > right_reg);
    assign status.below    = (ra_reg < start_reg);
    assign status.at_left  = (CW'(mid_reg) == left_reg);
    assign status.in_range = last || (next_start == '0) || (ra_reg < next_start);
    assign status.out_free = !out_valid_reg || !out_stall;

    `EITS_ASSERT_IMP(a_no_result_overwrite, clk, rst_n,
        cmd.out_load, !out_valid_reg || !out_stall,
        "pending result overwritten")

    `EITS_ASSERT_IMP(a_probe_in_table, clk, rst_n,
        cmd.probe, mid_wide < n_reg,
        "probe index beyond loaded entries")

endmodule

`default_nettype wire

/* rtl/exception_index_table_search.sv */
`default_nettype none

// Exception index table search. Holds up to TABLE_DEPTH 31-bit self-relative
// function offsets and answers "which entry covers this return address".
// A load request (kind = 0) writes one entry as it is accepted; loads at an
// index at or beyond TABLE_DEPTH are dropped. A lookup request (kind = 1)
// runs a binary search over the first entry_count entries (clamped to
// TABLE_DEPTH). Entry i starts at its sign-extended offset plus
// table_base + 8*i, mod 2^32, and its range ends just below the start of
// entry i+1; the last entry is open-ended. Each probe steps through the
// S_PROBE, S_RD0 and S_RD1 states because the offset memory has one read
// port and a probe needs two adjacent entries. The number of probes p is at
// most ceil(log2(entry_count + 1)) on a sorted table and at most entry_count
// on an unsorted one. Requests are taken only while the search engine is
// idle, but the result sits in its own register, so new requests are taken
// while a result waits on out_stall. Entries must be loaded before a lookup
// can read them; there is no clearing pass. Configuration (index 0:
// table_base, index 1: entry_count in bits 10..0) must be written only while
// no lookup is in flight; the block itself does not enforce this.

module exception_index_table_search #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    // configuration write port
    input  wire logic                             cfg_we,
    input  wire logic [eits_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [31:0]                      cfg_wdata,

    // request channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire eits_pkg::in_req_t                in_req,

    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output eits_pkg::out_res_t                    out_res
);

    eits_pkg::cmd_t    cmd;
    eits_pkg::status_t status;

    // search sequencer: accepts requests, steps probes, hands off results
    eits_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_req.kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // offset memory, search window, start computation and result register
    eits_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_req    (in_req),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

endmodule

`default_nettype wire
